### hdl/rscc_pkg.sv
// Shared types, codes and field arithmetic for the running-sum constraint checker.
`timescale 1ns / 1ps
`default_nettype none

package rscc_pkg;

    // Goldilocks prime, 2^64 - 2^32 + 1.
    localparam logic [63:0] GL_P = 64'hFFFF_FFFF_0000_0001;

    localparam int FAIL_ROW_BITS  = 12;
    localparam int CFG_INDEX_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLAIMED = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEE     = 8'd1;

    // Failure codes carried in the verdict.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PUB    = 3'd1;
    localparam logic [2:0] KIND_COUNT  = 3'd2;
    localparam logic [2:0] KIND_INIT   = 3'd3;
    localparam logic [2:0] KIND_UPDATE = 3'd4;
    localparam logic [2:0] KIND_FINAL  = 3'd5;

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [63:0] amount;
        logic [63:0] running_sum;
        logic        last_row;
        logic        empty_trace;
    } item_t;

    typedef struct packed {
        logic                     accepted;
        logic [2:0]               fail_kind;
        logic [FAIL_ROW_BITS-1:0] fail_row;
    } verdict_t;

    // Values derived from the public registers, held ready for the back part.
    typedef struct packed {
        logic [63:0] target;
        logic        bound_bad;
    } check_cfg_t;

    function automatic logic [63:0] gl_reduce(input logic [63:0] x);
        logic [63:0] r;
        r = (x >= GL_P) ? (x - GL_P) : x;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rscc_front.sv
// Front part: takes input words, reduces both field values and holds them for the queue.
`timescale 1ns / 1ps
`default_nettype none

module rscc_front
    import rscc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       push,
    output item_t      push_word,
    input  wire logic  queue_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t word_reg;
    logic  take;

    assign item_stall = valid_reg && !queue_ready;
    assign take       = item_valid && !item_stall;
    assign push       = valid_reg && queue_ready;
    assign push_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Both cells are brought into canonical form here so that the back part
    // only has to compare reduced values.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.amount      <= gl_reduce(item.amount);
            word_reg.running_sum <= gl_reduce(item.running_sum);
            word_reg.last_row    <= item.last_row;
            word_reg.empty_trace <= item.empty_trace;
        end
    end

endmodule

`default_nettype wire

### hdl/rscc_queue.sv
// Short queue of reduced words between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module rscc_queue
    import rscc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_word,
    output logic       ready,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head
);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign ready      = (count_reg < QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_BITS'(QUEUE_DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### hdl/rscc_back.sv
// Back part: running-sum checks, trace state and the verdict output register.
`timescale 1ns / 1ps
`default_nettype none

module rscc_back
    import rscc_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int ROW_BITS = 12
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire item_t      head,
    output logic            pop,
    input  wire check_cfg_t check_cfg,
    output logic            verdict_valid,
    input  wire logic       verdict_stall,
    output verdict_t        verdict
);

    localparam logic [32:0] ROW_MAX_W = (33'd1 << ROW_BITS) - 33'd1;
    localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};
    localparam logic [ROW_BITS-1:0] COUNT_ROW =
        (33'(MAX_ROWS) > ROW_MAX_W) ? ROW_MAX : ROW_BITS'(MAX_ROWS);

    logic [63:0]         prev_sum_reg;
    logic [63:0]         prev_sum_next;
    logic [ROW_BITS-1:0] rows_seen_reg;
    logic [ROW_BITS-1:0] rows_seen_next;
    logic [2:0]          pend_kind_reg;
    logic [2:0]          pend_kind_next;
    logic [ROW_BITS-1:0] pend_row_reg;
    logic [ROW_BITS-1:0] pend_row_next;
    logic                verdict_valid_reg;
    logic                verdict_valid_next;
    verdict_t            verdict_reg;
    verdict_t            verdict_next;

    logic                is_verdict;
    logic                out_free;
    logic [64:0]         sum_wide;
    logic [64:0]         sum_less_p;
    logic [63:0]         expected;
    logic [2:0]          kind;
    logic [ROW_BITS-1:0] row;
    logic [31:0]         row_wide;

    assign is_verdict    = head.last_row || head.empty_trace;
    assign out_free      = !verdict_valid_reg || !verdict_stall;
    assign pop           = head_valid && (!is_verdict || out_free);
    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    // Field addition of the previous sum and this row's amount.
    always_comb
    begin
        sum_wide   = {1'b0, prev_sum_reg} + {1'b0, head.amount};
        sum_less_p = sum_wide - {1'b0, GL_P};
        expected   = (sum_wide >= {1'b0, GL_P}) ? sum_less_p[63:0] : sum_wide[63:0];
    end

    always_comb
    begin
        prev_sum_next  = prev_sum_reg;
        rows_seen_next = rows_seen_reg;
        pend_kind_next = pend_kind_reg;
        pend_row_next  = pend_row_reg;
        kind           = KIND_NONE;
        row            = '0;
        if (head.empty_trace)
        begin
            kind = KIND_PUB;
        end
        else
        begin
            if (pend_kind_reg == KIND_NONE)
            begin
                if (rows_seen_reg == '0)
                begin
                    if (head.running_sum != head.amount)
                    begin
                        pend_kind_next = KIND_INIT;
                        pend_row_next  = '0;
                    end
                end
                else if (head.running_sum != expected)
                begin
                    pend_kind_next = KIND_UPDATE;
                    pend_row_next  = rows_seen_reg - 1'b1;
                end
            end
            prev_sum_next = head.running_sum;
            if (rows_seen_reg != ROW_MAX)
            begin
                rows_seen_next = rows_seen_reg + 1'b1;
            end
            if (check_cfg.bound_bad)
            begin
                kind = KIND_PUB;
                row  = rows_seen_reg;
            end
            else if (33'(rows_seen_reg) >= 33'(MAX_ROWS))
            begin
                kind = KIND_COUNT;
                row  = COUNT_ROW;
            end
            else if (pend_kind_next != KIND_NONE)
            begin
                kind = pend_kind_next;
                row  = pend_row_next;
            end
            else if (head.running_sum != check_cfg.target)
            begin
                kind = KIND_FINAL;
                row  = rows_seen_reg;
            end
        end
        // Every verdict closes the trace.
        if (is_verdict)
        begin
            prev_sum_next  = '0;
            rows_seen_next = '0;
            pend_kind_next = KIND_NONE;
            pend_row_next  = '0;
        end
        row_wide               = 32'(row);
        verdict_next.accepted  = (kind == KIND_NONE);
        verdict_next.fail_kind = kind;
        verdict_next.fail_row  = row_wide[FAIL_ROW_BITS-1:0];
    end

    always_comb
    begin
        verdict_valid_next = verdict_valid_reg && verdict_stall;
        if (pop && is_verdict)
        begin
            verdict_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sum_reg      <= '0;
            rows_seen_reg     <= '0;
            pend_kind_reg     <= KIND_NONE;
            pend_row_reg      <= '0;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                prev_sum_reg  <= prev_sum_next;
                rows_seen_reg <= rows_seen_next;
                pend_kind_reg <= pend_kind_next;
                pend_row_reg  <= pend_row_next;
            end
            verdict_valid_reg <= verdict_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_verdict)
        begin
            verdict_reg <= verdict_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_verdict) |=> (rows_seen_reg == '0 && pend_kind_reg == KIND_NONE))
        else $error("trace state not cleared after a verdict");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_verdict) |-> out_free)
        else $error("verdict overwritten while still waiting");
`endif

endmodule

`default_nettype wire

### hdl/running_sum_constraint_checker.sv
// Top level of the running-sum constraint checker: configuration registers and the three parts.
`timescale 1ns / 1ps
`default_nettype none

// The block checks a trace of (amount, running sum) rows over the Goldilocks
// field, one row per input word, and returns one verdict word on the last row
// or on an empty-trace marker; other rows give no result. It sustains one row
// per clock cycle while the verdict consumer does not stall, a rate set by the
// back part, which adds each row's amount to the previous sum and compares the
// result combinationally. A row is taken into the front register, moves into
// the queue and is checked at the queue head, where a verdict word is loaded
// into the output register; the row or its verdict is held up only when the
// consumer stalls. A four-word queue separates the front from the back, so
// input is still taken while a verdict waits for its consumer, until the queue
// fills. The public claimed total and fee are written through the configuration
// port (index 0 and index 1); they must only be written while no word is in flight,
// and their reduced difference and range check are registered from the stored
// values. No memory is cleared after reset, so the block is ready at once.
module running_sum_constraint_checker
    import rscc_pkg::*;
#(
    parameter int MAX_ROWS        = 256,
    parameter int TERM_LIMIT_BITS = 62,
    parameter int ROW_BITS        = 12
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire item_t                     item,
    output logic                           verdict_valid,
    input  wire logic                      verdict_stall,
    output verdict_t                       verdict,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [63:0]               cfg_data
);

    logic        claimed_red_reg;
    logic [63:0] claimed_val_reg;
    logic [63:0] fee_val_reg;
    logic        claimed_big_reg;
    logic        fee_big_reg;
    check_cfg_t  check_cfg_reg;
    check_cfg_t  check_cfg_next;
    logic        cfg_write;
    logic        data_big;

    logic        push;
    item_t       push_word;
    logic        queue_ready;
    logic        pop;
    logic        head_valid;
    item_t       head;

    // The port never holds off a write.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A public value at or above the term limit fails the bound check; it is
    // judged on the raw value, before any reduction.
    assign data_big = |cfg_data[63:TERM_LIMIT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_red_reg <= 1'b0;
            claimed_val_reg <= '0;
            fee_val_reg     <= '0;
            claimed_big_reg <= 1'b0;
            fee_big_reg     <= 1'b0;
            check_cfg_reg   <= '0;
        end
        else
        begin
            claimed_red_reg <= cfg_write;
            if (cfg_write && cfg_index == REG_CLAIMED)
            begin
                claimed_val_reg <= gl_reduce(cfg_data);
                claimed_big_reg <= data_big;
            end
            if (cfg_write && cfg_index == REG_FEE)
            begin
                fee_val_reg <= gl_reduce(cfg_data);
                fee_big_reg <= data_big;
            end
            check_cfg_reg <= check_cfg_next;
        end
    end

    // Target for the final check: claimed minus fee in the field. It is
    // recomputed every cycle from the stored reduced values.
    always_comb
    begin
        check_cfg_next.target = claimed_val_reg - fee_val_reg;
        if (claimed_val_reg < fee_val_reg)
        begin
            check_cfg_next.target = claimed_val_reg - fee_val_reg + GL_P;
        end
        check_cfg_next.bound_bad = claimed_big_reg || fee_big_reg;
    end

    rscc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .push        (push),
        .push_word   (push_word),
        .queue_ready (queue_ready)
    );

    rscc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .ready      (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    rscc_back #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_BITS (ROW_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .check_cfg     (check_cfg_reg),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict)
    );

`ifndef SYNTHESIS
    a_cfg_settles: assert property (@(posedge clk) disable iff (!rst_n)
        claimed_red_reg |-> (check_cfg_next.bound_bad == (claimed_big_reg || fee_big_reg)))
        else $error("bound flag does not follow the stored public values");
`endif

endmodule

`default_nettype wire

### tb/running_sum_constraint_checker_tb.sv
// Self-checking testbench for the running-sum constraint checker.
`timescale 1ns / 1ps

// The bench drives traces of (amount, running sum) rows into the checker and
// predicts every verdict word from its own model of the Goldilocks field
// arithmetic and of the ranking of failures. It begins with a short table of
// hand-picked rows, a few of which carry their verdict typed in. Two
// full-length traces follow: one at the row limit and one just over it. The
// rest is random traces. Most of these are well formed and end on the public
// target. The remainder carry a corrupted sum, a closing sum that misses, an
// empty marker part-way through, or both marks on one row. The item and
// verdict sides each idle in random bursts. The final stretch has no idling at all.
module running_sum_constraint_checker_tb;
    import rscc_pkg::*;

    localparam int MAX_ROWS        = 256;
    localparam int TERM_LIMIT_BITS = 62;
    localparam int ROW_BITS        = 12;

    localparam int    CLK_PERIOD    = 8;
    localparam int    RESET_CYCLES  = 12;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    RANDOM_ROWS   = 210;
    localparam int    QUIET_ROWS    = 60;    // the closing stretch that runs without idling
    localparam int    REPORT_LIMIT  = 10;
    localparam longint LIMIT_NS     = 64'd8_000_000;

    localparam logic [63:0]         PUB_LIMIT = 64'd1 << TERM_LIMIT_BITS;
    localparam logic [ROW_BITS-1:0] ROW_CEIL  = '1;

    // A table row whose verdict is not typed in takes it from the predictor.
    localparam logic [2:0] BY_PREDICTOR = 3'd7;

    typedef struct {
        bit                       is_write;   // write the public values rather than send a row
        logic [63:0]              a;          // amount, or the claimed total for a write
        logic [63:0]              b;          // running sum, or the fee for a write
        bit                       last;
        bit                       empty;
        logic [2:0]               kind;
        logic [FAIL_ROW_BITS-1:0] row;
    } plan_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      item_valid    = 1'b0;
    logic                      item_stall;
    item_t                     item          = '0;
    logic                      verdict_valid;
    logic                      verdict_stall = 1'b0;
    verdict_t                  verdict;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [63:0]               cfg_data      = '0;

    // The predictor's copy of the public registers and of the trace state.
    logic [63:0]              claimed_reg    = '0;
    logic [63:0]              fee_reg        = '0;
    logic [63:0]              trace_prev_sum = '0;
    logic [ROW_BITS-1:0]      trace_rows     = '0;
    logic [2:0]               held_kind      = KIND_NONE;
    logic [FAIL_ROW_BITS-1:0] held_row       = '0;

    verdict_t verdict_due[$];
    plan_t    directed_plan[$];

    bit idle_on       = 1'b0;
    int stall_left    = 0;
    int failures      = 0;
    int rows_sent     = 0;
    int traces_sent   = 0;
    int longest_trace = 0;
    int verdicts_seen = 0;
    int kind_count[8];

    running_sum_constraint_checker #(
        .MAX_ROWS        (MAX_ROWS),
        .TERM_LIMIT_BITS (TERM_LIMIT_BITS),
        .ROW_BITS        (ROW_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Field arithmetic. Both operands of the addition and subtraction are
    // already reduced, so a single correction by the modulus is enough.
    function automatic logic [63:0] fold_p(input logic [63:0] x);
        return (x >= GL_P) ? x - GL_P : x;
    endfunction

    function automatic logic [63:0] add_p(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, GL_P})
        begin
            s = s - {1'b0, GL_P};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_p(input logic [63:0] x, input logic [63:0] y);
        return (x >= y) ? x - y : x + (GL_P - y);
    endfunction

    // Small values also have a second, unreduced spelling above the modulus.
    function automatic logic [63:0] maybe_alias(input logic [63:0] v);
        if (v <= 64'hFFFF_FFFE && $urandom_range(0, 3) == 0)
        begin
            return v + GL_P;
        end
        return v;
    endfunction

    function automatic void forget_trace();
        trace_prev_sum = '0;
        trace_rows     = '0;
        held_kind      = KIND_NONE;
        held_row       = '0;
    endfunction

    // Works out the verdict, if any, that one accepted row word gives, and
    // moves the trace state on. The ranking is: empty marker, public values
    // out of range, too many rows, the first init or update failure, and
    // finally the closing sum against claimed minus fee.
    function automatic void judge_row(input item_t w, output bit gives, output verdict_t v);
        logic [63:0]         amt;
        logic [63:0]         sum;
        logic [ROW_BITS-1:0] idx;
        amt   = fold_p(w.amount);
        sum   = fold_p(w.running_sum);
        idx   = trace_rows;
        gives = 1'b0;
        v     = '0;
        if (w.empty_trace)
        begin
            // An empty marker wins over everything, rows already taken included.
            gives       = 1'b1;
            v.fail_kind = KIND_PUB;
            forget_trace();
            return;
        end
        if (held_kind == KIND_NONE)
        begin
            if (idx == '0)
            begin
                if (sum != amt)
                begin
                    held_kind = KIND_INIT;
                    held_row  = '0;
                end
            end
            else if (sum != add_p(trace_prev_sum, amt))
            begin
                // An update failure names the row before the one that broke.
                held_kind = KIND_UPDATE;
                held_row  = FAIL_ROW_BITS'(idx - 1'b1);
            end
        end
        trace_prev_sum = sum;
        if (trace_rows != ROW_CEIL)
        begin
            trace_rows = trace_rows + 1'b1;
        end
        if (!w.last_row)
        begin
            return;
        end
        gives = 1'b1;
        if (claimed_reg >= PUB_LIMIT || fee_reg >= PUB_LIMIT)
        begin
            v.fail_kind = KIND_PUB;
            v.fail_row  = FAIL_ROW_BITS'(idx);
        end
        else if (int'(idx) + 1 > MAX_ROWS)
        begin
            v.fail_kind = KIND_COUNT;
            v.fail_row  = FAIL_ROW_BITS'(MAX_ROWS);
        end
        else if (held_kind != KIND_NONE)
        begin
            v.fail_kind = held_kind;
            v.fail_row  = held_row;
        end
        else if (sum != sub_p(fold_p(claimed_reg), fold_p(fee_reg)))
        begin
            v.fail_kind = KIND_FINAL;
            v.fail_row  = FAIL_ROW_BITS'(idx);
        end
        v.accepted = (v.fail_kind == KIND_NONE);
        forget_trace();
    endfunction

    task automatic report(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // Offers one row word and waits for it to be taken. The valid is only
    // lowered for an idle burst, so back-to-back words keep it high.
    task automatic send_row(input item_t w, input logic [2:0] typed_kind,
                            input logic [FAIL_ROW_BITS-1:0] typed_row);
        bit       gives;
        verdict_t v;
        verdict_t typed;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        judge_row(w, gives, v);
        if (typed_kind != BY_PREDICTOR)
        begin
            typed.accepted  = (typed_kind == KIND_NONE);
            typed.fail_kind = typed_kind;
            typed.fail_row  = typed_row;
            verdict_due.push_back(typed);
        end
        else if (gives)
        begin
            verdict_due.push_back(v);
        end
        rows_sent++;
        @(negedge clk);
    endtask

    // Lets every due verdict arrive, then gives the pipeline time to empty.
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (verdict_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes both public registers in turn, keeping the valid high between them.
    task automatic set_public(input logic [63:0] claimed, input logic [63:0] fee);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CLAIMED;
        cfg_data  <= claimed;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        claimed_reg = claimed;
        @(negedge clk);
        cfg_index <= REG_FEE;
        cfg_data  <= fee;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        fee_reg = fee;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Public values lean towards the legal range so that most traces reach
    // the later checks. Both ends of the range, the bound itself and all ones also occur.
    function automatic logic [63:0] pick_public();
        case ($urandom_range(0, 11))
            6:       return '0;
            7:       return PUB_LIMIT - 1'b1;
            8:       return PUB_LIMIT;
            9:       return '1;
            10:      return {$urandom, $urandom};
            11:      return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom} >> (64 - TERM_LIMIT_BITS);
        endcase
    endfunction

    // Sends one trace of the given length. A clean trace is well formed and
    // ends on the target. Otherwise a sum may be corrupted, the closing sum
    // may miss, and an empty marker may cut the trace short.
    task automatic send_trace(input int len, input bit clean);
        logic [63:0] target;
        logic [63:0] acc;
        logic [63:0] amt;
        logic [63:0] sum;
        item_t       w;
        int          bad_at;
        target = sub_p(fold_p(claimed_reg), fold_p(fee_reg));
        bad_at = (!clean && $urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        acc    = '0;
        traces_sent++;
        if (len > longest_trace)
        begin
            longest_trace = len;
        end
        for (int r = 0; r < len; r++)
        begin
            case ($urandom_range(0, 4))
                0:       amt = {$urandom, $urandom};
                1:       amt = 64'($urandom_range(0, 1000));
                2:       amt = GL_P - 64'($urandom_range(1, 16));
                3:       amt = ~64'($urandom_range(0, 16));
                default: amt = {$urandom, $urandom} >> $urandom_range(1, 40);
            endcase
            if (r == len - 1 && (clean || $urandom_range(0, 9) != 0))
            begin
                amt = sub_p(target, acc);
            end
            sum = (r == 0) ? fold_p(amt) : add_p(acc, fold_p(amt));
            if (r == bad_at)
            begin
                sum = sum ^ (64'd1 << $urandom_range(0, 63));
            end
            else
            begin
                sum = maybe_alias(sum);
            end
            acc              = fold_p(sum);
            w.amount         = maybe_alias(amt);
            w.running_sum    = sum;
            w.last_row       = (r == len - 1);
            w.empty_trace    = 1'b0;
            if (!clean && $urandom_range(0, 59) == 0)
            begin
                w.empty_trace = 1'b1;
                w.last_row    = 1'($urandom_range(0, 1));
                send_row(w, BY_PREDICTOR, '0);
                return;
            end
            send_row(w, BY_PREDICTOR, '0);
        end
    endtask

    function automatic plan_t plan_row(input logic [63:0] a, input logic [63:0] b,
                                       input bit last, input bit empty,
                                       input logic [2:0] kind,
                                       input logic [FAIL_ROW_BITS-1:0] row);
        plan_t p;
        p.is_write = 1'b0;
        p.a        = a;
        p.b        = b;
        p.last     = last;
        p.empty    = empty;
        p.kind     = kind;
        p.row      = row;
        return p;
    endfunction

    function automatic plan_t plan_write(input logic [63:0] claimed, input logic [63:0] fee);
        plan_t p;
        p          = plan_row(claimed, fee, 1'b0, 1'b0, BY_PREDICTOR, '0);
        p.is_write = 1'b1;
        return p;
    endfunction

    // The verdict side stalls in random bursts whenever idling is switched on.
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 18);
        end
        verdict_stall <= (stall_left != 0);
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
        end
    end

    // Every verdict word taken is compared, field by field, with the oldest
    // one still due.
    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && verdict_valid === 1'b1 && verdict_stall === 1'b0)
        begin
            if (verdict_due.size() == 0)
            begin
                report($sformatf("verdict with none due: accepted=%0b kind=%0d row=%0d",
                                 verdict.accepted, verdict.fail_kind, verdict.fail_row));
            end
            else
            begin
                want = verdict_due.pop_front();
                if (verdict.accepted !== want.accepted || verdict.fail_kind !== want.fail_kind
                    || verdict.fail_row !== want.fail_row)
                begin
                    report($sformatf({"verdict %0d: expected accepted=%0b kind=%0d row=%0d,",
                                      " got accepted=%0b kind=%0d row=%0d"},
                                     verdicts_seen, want.accepted, want.fail_kind, want.fail_row,
                                     verdict.accepted, verdict.fail_kind, verdict.fail_row));
                end
                kind_count[want.fail_kind]++;
                verdicts_seen++;
            end
        end
    end

    initial
    begin
        item_t w;
        int    len;
        int    first_random;

        // Hand-picked rows, starting from the public values at their reset state.
        directed_plan.push_back(plan_write(64'd0, 64'd0));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b0, 1'b1, KIND_PUB, '0));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b1, 1'b0, KIND_NONE, '0));
        // The modulus itself folds to zero.
        directed_plan.push_back(plan_row(GL_P, 64'd0, 1'b1, 1'b0, BY_PREDICTOR, '0));
        // All ones folds to 2^32 - 2; the init check holds but the closing sum misses.
        directed_plan.push_back(plan_row('1, 64'h0000_0000_FFFF_FFFE, 1'b1, 1'b0,
                                         BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd5, 64'd6, 1'b1, 1'b0, KIND_INIT, '0));
        // Both marks on one word: the empty marker takes precedence.
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b1, 1'b1, KIND_PUB, '0));
        // A broken update on the second row names the first.
        directed_plan.push_back(plan_row(64'd3, 64'd3, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd4, 64'd8, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd0, 64'd8, 1'b1, 1'b0, BY_PREDICTOR, '0));
        // An empty marker part-way through drops the rows taken so far.
        directed_plan.push_back(plan_row(64'd1, 64'd1, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd9, 64'd9, 1'b0, 1'b1, KIND_PUB, '0));
        // The init failure comes first and hides the later update failure.
        directed_plan.push_back(plan_row(64'd2, 64'd1, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd1, 64'd5, 1'b1, 1'b0, BY_PREDICTOR, '0));
        // Target of seven.
        directed_plan.push_back(plan_write(64'd10, 64'd3));
        directed_plan.push_back(plan_row(64'd3, 64'd3, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd4, 64'd7, 1'b1, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd6, 64'd6, 1'b1, 1'b0, KIND_FINAL, '0));
        // A fee above the claim wraps the target to p - 1; the sums wrap round too.
        directed_plan.push_back(plan_write(64'd0, 64'd1));
        directed_plan.push_back(plan_row('1, '1, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'hFFFF_FFFE_0000_0002, GL_P - 64'd1, 1'b0, 1'b0,
                                         BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd2, 64'd1, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(GL_P - 64'd2, GL_P - 64'd1, 1'b1, 1'b0,
                                         BY_PREDICTOR, '0));
        // A claim exactly at the bound fails on the last row's index.
        directed_plan.push_back(plan_write(PUB_LIMIT, 64'd0));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b0, 1'b0, BY_PREDICTOR, '0));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b1, 1'b0, KIND_PUB, 12'd1));
        directed_plan.push_back(plan_write(PUB_LIMIT - 64'd1, '1));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b1, 1'b0, KIND_PUB, '0));
        // Both just under the bound: a target of zero.
        directed_plan.push_back(plan_write(PUB_LIMIT - 64'd1, PUB_LIMIT - 64'd1));
        directed_plan.push_back(plan_row(64'd0, 64'd0, 1'b1, 1'b0, KIND_NONE, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_write)
            begin
                wait_drain();
                set_public(directed_plan[i].a, directed_plan[i].b);
            end
            else
            begin
                w.amount      = directed_plan[i].a;
                w.running_sum = directed_plan[i].b;
                w.last_row    = directed_plan[i].last;
                w.empty_trace = directed_plan[i].empty;
                send_row(w, directed_plan[i].kind, directed_plan[i].row);
            end
        end

        // Full-length traces: exactly the limit passes and one row more fails
        // the count check.
        wait_drain();
        set_public(64'd1000, 64'd1);
        send_trace(MAX_ROWS, 1'b1);
        send_trace(MAX_ROWS + 1, 1'b1);

        // Random phases, each with fresh public values and a few traces.
        first_random = rows_sent;
        while (rows_sent < first_random + RANDOM_ROWS)
        begin
            wait_drain();
            set_public(pick_public(), pick_public());
            idle_on = (rows_sent < first_random + RANDOM_ROWS - QUIET_ROWS)
                      && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    // A lone empty marker with random content in the ignored fields.
                    w.amount      = {$urandom, $urandom};
                    w.running_sum = {$urandom, $urandom};
                    w.last_row    = 1'($urandom_range(0, 1));
                    w.empty_trace = 1'b1;
                    traces_sent++;
                    send_row(w, BY_PREDICTOR, '0);
                end
                else
                begin
                    case ($urandom_range(0, 79))
                        0:       len = $urandom_range(MAX_ROWS - 2, MAX_ROWS + 2);
                        1, 2, 3, 4, 5, 6:
                                 len = $urandom_range(9, 40);
                        default: len = $urandom_range(1, 8);
                    endcase
                    send_trace(len, 1'b0);
                end
            end
        end

        idle_on = 1'b0;
        wait_drain();

        $display("Sent %0d row words in %0d traces (longest %0d rows); checked %0d verdicts.",
                 rows_sent, traces_sent, longest_trace, verdicts_seen);
        $display({"Verdicts by kind (none, public/empty, count, init, update, final):",
                  " %0d %0d %0d %0d %0d %0d"},
                 kind_count[KIND_NONE], kind_count[KIND_PUB], kind_count[KIND_COUNT],
                 kind_count[KIND_INIT], kind_count[KIND_UPDATE], kind_count[KIND_FINAL]);
        if (failures == 0)
        begin
            $display("running_sum_constraint_checker_tb: clean");
        end
        else
        begin
            $display("%0d failures in total", failures);
            $display("running_sum_constraint_checker_tb: errors");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("Timed out with %0d verdicts still due.", verdict_due.size());
        $display("running_sum_constraint_checker_tb: errors");
        $finish;
    end

endmodule

### sim.f
hdl/rscc_pkg.sv
hdl/rscc_front.sv
hdl/rscc_queue.sv
hdl/rscc_back.sv
hdl/running_sum_constraint_checker.sv
tb/running_sum_constraint_checker_tb.sv
